// ===== design/frs_pkg.sv =====
package frs_pkg;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned VAL_W  = 64;
  localparam int unsigned SIZE_W = 11;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic OP_SET = 1'b0;
  localparam logic OP_SUM = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_DIFF,
    ST_SET_WALK,
    ST_SUM_WALK,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic clearing;
    logic set_walk;
  } stat_t;

endpackage

// ===== design/frs_mem.sv =====
module frs_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 64
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/frs_ctrl.sv =====
module frs_ctrl
  import frs_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned AW          = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SIZE_W-1:0] size_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [IDX_W-1:0]  index_a_i,
  input  logic [IDX_W-1:0]  index_b_i,
  input  logic [VAL_W-1:0]  value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [VAL_W-1:0]  range_sum_o,
  output logic              range_error_o,
  output logic              tree_we_o,
  output logic [AW-1:0]     tree_waddr_o,
  output logic [VAL_W-1:0]  tree_wdata_o,
  output logic [AW-1:0]     tree_raddr_o,
  input  logic [VAL_W-1:0]  tree_rdata_i,
  output logic              plain_we_o,
  output logic [AW-1:0]     plain_waddr_o,
  output logic [VAL_W-1:0]  plain_wdata_o,
  output logic [AW-1:0]     plain_raddr_o,
  input  logic [VAL_W-1:0]  plain_rdata_i,
  output stat_t             stat_o
);

  localparam int unsigned WW = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;
  localparam logic [WW-1:0] MaxW  = WW'(MAX_ENTRIES);
  localparam logic [WW-1:0] LastW = WW'(MAX_ENTRIES - 1);

  st_e              state_q, state_d;
  logic [WW-1:0]    ptr_q, ptr_d;
  logic [WW-1:0]    lo_q, lo_d;
  logic             phase_q, phase_d;
  logic             pend_q, pend_d;
  logic             pend_neg_q, pend_neg_d;
  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] acc_q, acc_d;
  logic [VAL_W-1:0] diff_q, diff_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic             err_q, err_d;
  logic [VAL_W-1:0] out_sum_q, out_sum_d;
  logic             out_err_q, out_err_d;

  logic [WW-1:0]    size_w, eff_w, a_w, b_w;
  logic [WW-1:0]    ptr_dec, ptr_up, ptr_low;
  logic [VAL_W-1:0] acc_upd;
  logic             out_free;

  always_comb begin
    size_w   = WW'(size_i);
    eff_w    = (size_w > MaxW) ? MaxW : size_w;
    a_w      = WW'(index_a_i);
    b_w      = WW'(index_b_i);
    ptr_dec  = ptr_q - WW'(1);
    ptr_up   = ptr_q | (ptr_q + WW'(1));
    ptr_low  = ptr_q & ptr_dec;
    out_free = !out_valid_q || !out_stall_i;
    if (pend_q) begin
      acc_upd = pend_neg_q ? (acc_q - tree_rdata_i) : (acc_q + tree_rdata_i);
    end else begin
      acc_upd = acc_q;
    end
  end

  always_comb begin
    state_d       = state_q;
    ptr_d         = ptr_q;
    lo_d          = lo_q;
    phase_d       = phase_q;
    pend_d        = pend_q;
    pend_neg_d    = pend_neg_q;
    acc_d         = acc_q;
    diff_d        = diff_q;
    val_d         = val_q;
    err_d         = err_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_sum_d     = out_sum_q;
    out_err_d     = out_err_q;
    in_stall_o    = 1'b1;
    tree_we_o     = 1'b0;
    tree_waddr_o  = ptr_q[AW-1:0];
    tree_wdata_o  = tree_rdata_i + diff_q;
    tree_raddr_o  = ptr_q[AW-1:0];
    plain_we_o    = 1'b0;
    plain_waddr_o = ptr_q[AW-1:0];
    plain_wdata_o = val_q;
    plain_raddr_o = a_w[AW-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        tree_we_o     = 1'b1;
        tree_wdata_o  = '0;
        plain_we_o    = 1'b1;
        plain_wdata_o = '0;
        if (ptr_q == LastW) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + WW'(1);
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (operation_i == OP_SET) begin
            if (a_w < eff_w) begin
              ptr_d   = a_w;
              val_d   = value_i;
              state_d = ST_SET_DIFF;
            end
          end else if ((a_w > b_w) || (b_w >= eff_w)) begin
            acc_d   = '0;
            err_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            ptr_d   = b_w + WW'(1);
            lo_d    = a_w;
            phase_d = 1'b0;
            pend_d  = 1'b0;
            acc_d   = '0;
            err_d   = 1'b0;
            state_d = ST_SUM_WALK;
          end
        end
      end
      ST_SET_DIFF: begin
        diff_d     = val_q - plain_rdata_i;
        plain_we_o = 1'b1;
        state_d    = ST_SET_WALK;
      end
      ST_SET_WALK: begin
        tree_we_o = 1'b1;
        if (ptr_up < MaxW) begin
          tree_raddr_o = ptr_up[AW-1:0];
          ptr_d        = ptr_up;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SUM_WALK: begin
        acc_d        = acc_upd;
        tree_raddr_o = ptr_dec[AW-1:0];
        if (ptr_q != '0) begin
          pend_d     = 1'b1;
          pend_neg_d = phase_q;
          ptr_d      = ptr_low;
        end else begin
          pend_d = 1'b0;
          if (!phase_q) begin
            ptr_d   = lo_q;
            phase_d = 1'b1;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sum_d   = acc_q;
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ptr_q       <= '0;
      phase_q     <= 1'b0;
      pend_q      <= 1'b0;
      pend_neg_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      phase_q     <= phase_d;
      pend_q      <= pend_d;
      pend_neg_q  <= pend_neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    diff_q    <= diff_d;
    val_q     <= val_d;
    err_q     <= err_d;
    lo_q      <= lo_d;
    out_sum_q <= out_sum_d;
    out_err_q <= out_err_d;
  end

  assign out_valid_o     = out_valid_q;
  assign range_sum_o     = out_sum_q;
  assign range_error_o   = out_err_q;
  assign stat_o.clearing = (state_q == ST_CLEAR);
  assign stat_o.set_walk = (state_q == ST_SET_WALK);

endmodule

// ===== design/fenwick_range_sum_point_set.sv =====
// Channel   Direction  Handshake                 Word
// in        input      in_valid_i / in_stall_o   operation, index_a, index_b, value
// out       output     out_valid_o / out_stall_i range_sum, range_error
// cfg       input      cfg_valid_i / cfg_ready_o active_size
//
// A set reads the old plain value, stores the new one and then updates each tree
// entry on its update chain, at most log2(MAX_ENTRIES) + 1 entries; each step
// reads and writes the tree memory once. A sum runs two prefix walks, one tree
// read per step, through the single tree read port. After reset a clearing pass
// over all MAX_ENTRIES words zeroes both memories while the input is stalled;
// configuration writes are taken at any time.
// A sum result waits in the output register, and a new item is taken meanwhile.
module fenwick_range_sum_point_set
  import frs_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [SIZE_W-1:0]       cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    operation_i,
  input  logic [IDX_W-1:0]        index_a_i,
  input  logic [IDX_W-1:0]        index_b_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] range_sum_o,
  output logic                    range_error_o
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);

  logic [SIZE_W-1:0] active_size_q;
  logic [SIZE_W-1:0] active_size_d;

  logic              tree_we;
  logic [AW-1:0]     tree_waddr;
  logic [VAL_W-1:0]  tree_wdata;
  logic [AW-1:0]     tree_raddr;
  logic [VAL_W-1:0]  tree_rdata;
  logic              plain_we;
  logic [AW-1:0]     plain_waddr;
  logic [VAL_W-1:0]  plain_wdata;
  logic [AW-1:0]     plain_raddr;
  logic [VAL_W-1:0]  plain_rdata;
  logic [VAL_W-1:0]  sum_raw;
  stat_t             stat;

  assign cfg_ready_o   = 1'b1;
  assign active_size_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : active_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_size_q <= SIZE_RESET;
    end else begin
      active_size_q <= active_size_d;
    end
  end

  frs_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW),
    .DW    (VAL_W)
  ) u_tree_mem (
    .clk_i   (clk_i),
    .we_i    (tree_we),
    .waddr_i (tree_waddr),
    .wdata_i (tree_wdata),
    .raddr_i (tree_raddr),
    .rdata_o (tree_rdata)
  );

  frs_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW),
    .DW    (VAL_W)
  ) u_plain_mem (
    .clk_i   (clk_i),
    .we_i    (plain_we),
    .waddr_i (plain_waddr),
    .wdata_i (plain_wdata),
    .raddr_i (plain_raddr),
    .rdata_o (plain_rdata)
  );

  frs_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .size_i        (active_size_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .index_a_i     (index_a_i),
    .index_b_i     (index_b_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .range_sum_o   (sum_raw),
    .range_error_o (range_error_o),
    .tree_we_o     (tree_we),
    .tree_waddr_o  (tree_waddr),
    .tree_wdata_o  (tree_wdata),
    .tree_raddr_o  (tree_raddr),
    .tree_rdata_i  (tree_rdata),
    .plain_we_o    (plain_we),
    .plain_waddr_o (plain_waddr),
    .plain_wdata_o (plain_wdata),
    .plain_raddr_o (plain_raddr),
    .plain_rdata_i (plain_rdata),
    .stat_o        (stat)
  );

  assign range_sum_o = sum_raw;

`ifndef SYNTHESIS
  // Storing a new value is always followed by the first tree update of its chain.
  a_set_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plain_we && !stat.clearing |=> tree_we && stat.set_walk)
    else $error("set did not start its tree update");

  // Tree updates of a set never coincide with the plain value write.
  a_walk_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tree_we && !stat.clearing |-> !plain_we)
    else $error("tree update overlaps plain value write");

  // No word is taken while the memories are being cleared, and both memories are written.
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> in_stall_o && tree_we && plain_we)
    else $error("input open during clearing pass");
`endif

endmodule
